### src/nbg_pkg.sv
package nbg_pkg;

  // One stored body record, packed from the lowest bit up: px, py, vx, vy, mass, radius.
  typedef struct packed {
    logic [23:0] radius;
    logic [31:0] mass;
    logic [39:0] vy;
    logic [39:0] vx;
    logic [39:0] py;
    logic [39:0] px;
  } body_t;

  localparam logic [1:0] REG_TIME_STEP = 2'd0;
  localparam logic [1:0] REG_GRAV      = 2'd1;
  localparam logic [1:0] REG_ESCAPE    = 2'd2;

  localparam logic [7:0]  TIME_STEP_RST = 8'd16;
  localparam logic [31:0] GRAV_RST      = 32'd4294967;
  localparam logic [14:0] ESCAPE_RST    = 15'd2000;

  // ceil(2^25 / 3): x * DIV3_RECIP >> 25 equals x / 3 for every 24-bit x.
  localparam logic [24:0] DIV3_RECIP = 25'd11184811;

  function automatic logic [39:0] sat40(input logic signed [63:0] v);
    logic [39:0] r;
    if (v > 64'sd549755813887) begin
      r = 40'h7F_FFFF_FFFF;
    end else if (v < -64'sd549755813888) begin
      r = 40'h80_0000_0000;
    end else begin
      r = v[39:0];
    end
    return r;
  endfunction

endpackage

### src/nbg_body_mem.sv
module nbg_body_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  nbg_pkg::body_t    wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output nbg_pkg::body_t    rdata_o
);

  nbg_pkg::body_t mem [DEPTH];
  nbg_pkg::body_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/nbg_sqrt.sv
module nbg_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] value_i,
  output logic [31:0] root_o,
  output logic        done_o
);

  logic [63:0] val_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic        done_q;

  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        fits;

  // Two radicand bits enter the partial remainder each cycle; one root bit leaves.
  assign rem_sh = {rem_q, val_q[63:62]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= value_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q <= {val_q[61:0], 2'b00};
      if (fits) begin
        rem_q  <= 34'(rem_sh - trial);
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[33:0];
        root_q <= {root_q[30:0], 1'b0};
      end
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

### src/nbg_div.sv
module nbg_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [63:0] divisor_i,
  output logic [63:0] quotient_o,
  output logic        done_o
);

  logic [63:0] quo_q;
  logic [63:0] rem_q;
  logic [63:0] dvs_q;
  logic [6:0]  cnt_q;
  logic        busy_q;
  logic        done_q;

  logic [64:0] rem_sh;
  logic        fits;

  // Restoring division, one quotient bit per cycle.
  assign rem_sh = {rem_q, quo_q[63]};
  assign fits   = (rem_sh >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd64;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= 64'(rem_sh - {1'b0, dvs_q});
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= rem_sh[63:0];
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

### src/nbody_gravity_step.sv
// A load takes the mass through the shared square-root unit, then writes the body record.
// A step takes each interacting pair through the square-root unit and three divisions in the
// shared divider; a close pair returns to the scan after the distance check. Each alive body
// is read, updated and written back, and slots that are not alive are skipped.
// One item is in work at a time; results leave through a registered output stage.
// Reset clears the alive bits, the live count and loads the register defaults;
// the body memory is not cleared; its data is used only for alive slots, all of them loaded.
module nbody_gravity_step #(
  parameter int unsigned MAX_BODIES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // slot[3:0], pos_x[43:4], pos_y[83:44], vel_x[123:84], vel_y[163:124], body_mass[195:164]
  input  logic [199:0] s_axis_tdata,
  // op[0]
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_slot[3:0], alive[4], new_pos_x[44:5], new_pos_y[84:45], new_vel_x[124:85],
  // new_vel_y[164:125], live_count[169:165]
  output logic [175:0] m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  localparam int unsigned IW = $clog2(MAX_BODIES);
  localparam int unsigned NW = IW + 1;
  localparam int unsigned CW = $clog2(MAX_BODIES + 1);
  localparam logic [NW-1:0] END_IDX  = NW'(MAX_BODIES);
  localparam logic [NW-1:0] LAST_IDX = NW'(MAX_BODIES - 1);

  typedef enum logic [23:0] {
    S_IDLE     = 24'h000001,
    S_LD_SQ    = 24'h000002,
    S_LD_WR    = 24'h000004,
    S_SCAN_I   = 24'h000008,
    S_RD_I     = 24'h000010,
    S_SCAN_J   = 24'h000020,
    S_RD_J     = 24'h000040,
    S_MUL1     = 24'h000080,
    S_MUL2     = 24'h000100,
    S_CHK      = 24'h000200,
    S_SQ       = 24'h000400,
    S_DS       = 24'h000800,
    S_DX       = 24'h001000,
    S_DY       = 24'h002000,
    S_TX0      = 24'h004000,
    S_TX1      = 24'h008000,
    S_TY0      = 24'h010000,
    S_TY1      = 24'h020000,
    S_UPD_V    = 24'h040000,
    S_UPD_P    = 24'h080000,
    S_WR_I     = 24'h100000,
    S_OUT_RD   = 24'h200000,
    S_OUT_LD   = 24'h400000,
    S_OUT_HOLD = 24'h800000
  } state_e;

  state_e state_q, state_d;

  logic [7:0]    ts_q;
  logic [31:0]   g_q;
  logic [14:0]   esc_q;
  logic [NW-1:0] i_q, j_q, k_q;
  logic [MAX_BODIES-1:0] alive_q;
  logic [CW-1:0] live_q;
  logic          m_valid_q;
  logic [175:0]  out_data_q;
  logic          out_last_q;

  // Payload registers.
  logic [IW-1:0] ld_slot_q;
  nbg_pkg::body_t ld_rec_q;
  logic [23:0]   ld_root_q;
  logic [39:0]   pix_q, piy_q, vix_q, viy_q;
  logic [31:0]   mi_q;
  logic [23:0]   ri_q, rj_q;
  logic [31:0]   mj_q;
  logic [28:0]   qx_q, qy_q;
  logic          sx_q, sy_q;
  logic [57:0]   qx2_q, qy2_q;
  logic [20:0]   lb_q;
  logic [63:0]   gm_q;
  logic [58:0]   dsq_q;
  logic [41:0]   lim_q;
  logic [39:0]   s_q;
  logic [24:0]   ux_q, uy_q;
  logic [44:0]   plo_q;
  logic [47:0]   ax_q, ay_q;
  logic [39:0]   nvx_q, nvy_q, npx_q, npy_q;

  // Input fields.
  logic          in_op;
  logic [3:0]    in_slot;
  logic [31:0]   in_mass;
  logic          accept_in;
  logic          slot_ok;

  assign in_op     = s_axis_tuser[0];
  assign in_slot   = s_axis_tdata[3:0];
  assign in_mass   = s_axis_tdata[195:164];
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept_in = s_axis_tvalid & s_axis_tready;
  assign slot_ok   = (32'(in_slot) < MAX_BODIES);
  assign cfg_ready_o = 1'b1;

  logic [IW-1:0] i_idx, j_idx, k_idx;
  assign i_idx = i_q[IW-1:0];
  assign j_idx = j_q[IW-1:0];
  assign k_idx = k_q[IW-1:0];

  // Body memory.
  logic           mem_we;
  logic [IW-1:0]  mem_waddr;
  nbg_pkg::body_t mem_wdata;
  logic [IW-1:0]  mem_raddr;
  nbg_pkg::body_t rd;
  logic [48:0]    rad_prod;

  assign rad_prod = ld_root_q * nbg_pkg::DIV3_RECIP;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = i_idx;
    mem_wdata = '{radius: ri_q, mass: mi_q, vy: nvy_q, vx: nvx_q, py: npy_q, px: npx_q};
    case (state_q)
      S_LD_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ld_slot_q;
        mem_wdata = ld_rec_q;
        mem_wdata.radius = rad_prod[48:25];
      end
      S_WR_I: begin
        mem_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (state_q)
      S_SCAN_J: mem_raddr = j_idx;
      S_OUT_RD: mem_raddr = k_idx;
      default:  mem_raddr = i_idx;
    endcase
  end

  nbg_body_mem #(
    .DEPTH (MAX_BODIES),
    .AW    (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rd)
  );

  // Pair geometry from the partner just read.
  logic [40:0] ddx, ddy, mgx, mgy;
  assign ddx = {rd.px[39], rd.px} - {pix_q[39], pix_q};
  assign ddy = {rd.py[39], rd.py} - {piy_q[39], piy_q};
  assign mgx = ddx[40] ? (~ddx + 41'd1) : ddx;
  assign mgy = ddy[40] ? (~ddy + 41'd1) : ddy;

  logic pair_pass;
  assign pair_pass = (dsq_q != '0) && !(dsq_q < 59'(lim_q));

  // Shared square-root unit.
  logic        sq_start, sq_done;
  logic [63:0] sq_op;
  logic [31:0] sq_root;

  assign sq_start = (accept_in & ~in_op & slot_ok) | ((state_q == S_CHK) & pair_pass);
  assign sq_op    = (state_q == S_IDLE) ? {16'b0, in_mass, 16'b0} : {5'b0, dsq_q};

  nbg_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (sq_op),
    .root_o  (sq_root),
    .done_o  (sq_done)
  );

  // Shared divider: magnitude first, then the two unit components.
  logic        dv_start, dv_done;
  logic [63:0] dv_num, dv_den, dv_quo;

  assign dv_start = ((state_q == S_SQ) & sq_done) |
                    (((state_q == S_DS) | (state_q == S_DX)) & dv_done);

  always_comb begin
    case (state_q)
      S_SQ: begin
        dv_num = gm_q;
        dv_den = {5'b0, dsq_q};
      end
      S_DS: begin
        dv_num = {11'b0, qx_q, 24'b0};
        dv_den = {32'b0, sq_root};
      end
      default: begin
        dv_num = {11'b0, qy_q, 24'b0};
        dv_den = {32'b0, sq_root};
      end
    endcase
  end

  nbg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dv_start),
    .dividend_i (dv_num),
    .divisor_i  (dv_den),
    .quotient_o (dv_quo),
    .done_o     (dv_done)
  );

  // Component term s*u >> 24, built from two 20-bit slices of s.
  logic        x_phase;
  logic [24:0] ux_sel;
  logic [44:0] m_lo, m_hi;
  logic [64:0] term_full;
  logic [47:0] term_e, term_add;

  assign x_phase   = (state_q == S_TX0) | (state_q == S_TX1);
  assign ux_sel    = x_phase ? ux_q : uy_q;
  assign m_lo      = s_q[19:0] * ux_sel;
  assign m_hi      = s_q[39:20] * ux_sel;
  assign term_full = {20'b0, plo_q} + {m_hi, 20'b0};
  assign term_e    = {7'b0, term_full[64:24]};
  assign term_add  = (x_phase ? sx_q : sy_q) ? (~term_e + 48'd1) : term_e;

  // Euler update.
  logic signed [56:0] avx, avy;
  logic signed [63:0] sumvx, sumvy;
  logic signed [48:0] pvx, pvy;
  logic signed [63:0] sumpx, sumpy;

  assign avx   = $signed(ax_q) * $signed({1'b0, ts_q});
  assign avy   = $signed(ay_q) * $signed({1'b0, ts_q});
  assign sumvx = 64'($signed(vix_q)) + 64'(avx);
  assign sumvy = 64'($signed(viy_q)) + 64'(avy);
  assign pvx   = $signed(nvx_q) * $signed({1'b0, ts_q});
  assign pvy   = $signed(nvy_q) * $signed({1'b0, ts_q});
  assign sumpx = 64'($signed(pix_q)) + 64'(pvx);
  assign sumpy = 64'($signed(piy_q)) + 64'(pvy);

  logic [39:0] magpx, magpy, esc_lim;
  logic        escaped;
  assign magpx   = npx_q[39] ? (~npx_q + 40'd1) : npx_q;
  assign magpy   = npy_q[39] ? (~npy_q + 40'd1) : npy_q;
  assign esc_lim = {1'b0, esc_q, 24'b0};
  assign escaped = (magpx > esc_lim) || (magpy > esc_lim);

  logic out_alive;
  assign out_alive = alive_q[k_idx];

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept_in) begin
          if (in_op) begin
            state_d = S_SCAN_I;
          end else if (slot_ok) begin
            state_d = S_LD_SQ;
          end
        end
      end
      S_LD_SQ:  if (sq_done) state_d = S_LD_WR;
      S_LD_WR:  state_d = S_IDLE;
      S_SCAN_I: begin
        if (i_q == END_IDX) begin
          state_d = S_OUT_RD;
        end else if (alive_q[i_idx]) begin
          state_d = S_RD_I;
        end
      end
      S_RD_I:   state_d = S_SCAN_J;
      S_SCAN_J: begin
        if (j_q == END_IDX) begin
          state_d = S_UPD_V;
        end else if ((j_q != i_q) && alive_q[j_idx]) begin
          state_d = S_RD_J;
        end
      end
      S_RD_J:   state_d = S_MUL1;
      S_MUL1:   state_d = S_MUL2;
      S_MUL2:   state_d = S_CHK;
      S_CHK:    state_d = pair_pass ? S_SQ : S_SCAN_J;
      S_SQ:     if (sq_done) state_d = S_DS;
      S_DS:     if (dv_done) state_d = S_DX;
      S_DX:     if (dv_done) state_d = S_DY;
      S_DY:     if (dv_done) state_d = S_TX0;
      S_TX0:    state_d = S_TX1;
      S_TX1:    state_d = S_TY0;
      S_TY0:    state_d = S_TY1;
      S_TY1:    state_d = S_SCAN_J;
      S_UPD_V:  state_d = S_UPD_P;
      S_UPD_P:  state_d = S_WR_I;
      S_WR_I:   state_d = S_SCAN_I;
      S_OUT_RD: state_d = S_OUT_LD;
      S_OUT_LD: state_d = S_OUT_HOLD;
      S_OUT_HOLD: begin
        if (m_axis_tready) begin
          state_d = out_last_q ? S_IDLE : S_OUT_RD;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      alive_q   <= '0;
      live_q    <= '0;
      m_valid_q <= 1'b0;
      ts_q      <= nbg_pkg::TIME_STEP_RST;
      g_q       <= nbg_pkg::GRAV_RST;
      esc_q     <= nbg_pkg::ESCAPE_RST;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          nbg_pkg::REG_TIME_STEP: ts_q  <= cfg_data_i[7:0];
          nbg_pkg::REG_GRAV:      g_q   <= cfg_data_i;
          nbg_pkg::REG_ESCAPE:    esc_q <= cfg_data_i[14:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (accept_in && in_op) i_q <= '0;
        end
        S_LD_WR: begin
          alive_q[ld_slot_q] <= 1'b1;
          if (!alive_q[ld_slot_q]) live_q <= live_q + CW'(1);
        end
        S_SCAN_I: begin
          if (i_q == END_IDX) begin
            k_q <= '0;
          end else if (!alive_q[i_idx]) begin
            i_q <= i_q + NW'(1);
          end
        end
        S_RD_I: j_q <= '0;
        S_SCAN_J: begin
          if ((j_q != END_IDX) && ((j_q == i_q) || !alive_q[j_idx])) begin
            j_q <= j_q + NW'(1);
          end
        end
        S_CHK: if (!pair_pass) j_q <= j_q + NW'(1);
        S_TY1: j_q <= j_q + NW'(1);
        S_WR_I: begin
          i_q <= i_q + NW'(1);
          if (escaped) begin
            alive_q[i_idx] <= 1'b0;
            live_q <= live_q - CW'(1);
          end
        end
        S_OUT_LD: m_valid_q <= 1'b1;
        S_OUT_HOLD: begin
          if (m_axis_tready) begin
            m_valid_q <= 1'b0;
            if (!out_last_q) k_q <= k_q + NW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        ld_slot_q       <= IW'(in_slot);
        ld_rec_q.px     <= s_axis_tdata[43:4];
        ld_rec_q.py     <= s_axis_tdata[83:44];
        ld_rec_q.vx     <= s_axis_tdata[123:84];
        ld_rec_q.vy     <= s_axis_tdata[163:124];
        ld_rec_q.mass   <= in_mass;
        ld_rec_q.radius <= '0;
      end
      S_LD_SQ: ld_root_q <= sq_root[23:0];
      S_RD_I: begin
        pix_q <= rd.px;
        piy_q <= rd.py;
        vix_q <= rd.vx;
        viy_q <= rd.vy;
        mi_q  <= rd.mass;
        ri_q  <= rd.radius;
        ax_q  <= '0;
        ay_q  <= '0;
      end
      S_RD_J: begin
        qx_q <= mgx[40:12];
        qy_q <= mgy[40:12];
        sx_q <= ddx[40];
        sy_q <= ddy[40];
        mj_q <= rd.mass;
        rj_q <= rd.radius;
      end
      S_MUL1: begin
        qx2_q <= qx_q * qx_q;
        qy2_q <= qy_q * qy_q;
        lb_q  <= 21'(({1'b0, ri_q} + {1'b0, rj_q}) >> 4);
        gm_q  <= g_q * mj_q;
      end
      S_MUL2: begin
        dsq_q <= {1'b0, qx2_q} + {1'b0, qy2_q};
        lim_q <= lb_q * lb_q;
      end
      S_DS: if (dv_done) s_q <= (|dv_quo[63:40]) ? 40'hFF_FFFF_FFFF : dv_quo[39:0];
      S_DX: if (dv_done) ux_q <= dv_quo[24:0];
      S_DY: if (dv_done) uy_q <= dv_quo[24:0];
      S_TX0: plo_q <= m_lo;
      S_TX1: ax_q  <= ax_q + term_add;
      S_TY0: plo_q <= m_lo;
      S_TY1: ay_q  <= ay_q + term_add;
      S_UPD_V: begin
        nvx_q <= nbg_pkg::sat40(sumvx);
        nvy_q <= nbg_pkg::sat40(sumvy);
      end
      S_UPD_P: begin
        npx_q <= nbg_pkg::sat40(sumpx);
        npy_q <= nbg_pkg::sat40(sumpy);
      end
      S_OUT_LD: begin
        out_data_q <= {6'b0, 5'(live_q),
                       out_alive ? rd.vy : 40'b0,
                       out_alive ? rd.vx : 40'b0,
                       out_alive ? rd.py : 40'b0,
                       out_alive ? rd.px : 40'b0,
                       out_alive, 4'(k_q)};
        out_last_q <= (k_q == LAST_IDX);
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

### src/nbg_checker.sv
module nbg_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [199:0] s_axis_tdata,
  input logic [0:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [175:0] m_axis_tdata,
  input logic         m_axis_tlast,
  input logic         cfg_valid_i,
  input logic         cfg_ready_o,
  input logic [1:0]   cfg_index_i,
  input logic [31:0]  cfg_data_i
);

  // A stalled result keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // No new item is taken while results of a step are still being delivered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input accepted during result stream");

  // A dead slot reports zero position and velocity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[4] |-> m_axis_tdata[164:5] == '0)
    else $error("dead slot with non-zero state");

  // After the final result the block is ready for the next item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready && !m_axis_tvalid)
    else $error("block not idle after final result");

endmodule

bind nbody_gravity_step nbg_checker u_nbg_checker (.*);
